[sv/rbcs_pkg.sv]
// Shared types and constants for the RGB breathing color sequencer.
package rbcs_pkg;

    localparam int LEVEL_W = 8;
    localparam int PHASE_W = 3;

    localparam logic [LEVEL_W-1:0] PEAK_RESET = 8'd255;
    localparam logic [LEVEL_W-1:0] RISE_STEP  = 8'd2;
    localparam logic [LEVEL_W-1:0] FALL_STEP  = 8'd2;

    typedef enum logic [PHASE_W-1:0] {
        PH_RED     = 3'd0,
        PH_GREEN   = 3'd1,
        PH_BLUE    = 3'd2,
        PH_MAGENTA = 3'd3,
        PH_YELLOW  = 3'd4,
        PH_CYAN    = 3'd5,
        PH_WHITE   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [PHASE_W-1:0] color_phase;
    } color_item_t;

endpackage

[sv/rbcs_if.sv]
// Valid/ready channel interfaces for tick items and color items.
interface rbcs_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface rbcs_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [2:0] color_phase;

    modport source (
        output valid, output red_level, output green_level, output blue_level,
        output color_phase, input ready
    );
    modport sink (
        input valid, input red_level, input green_level, input blue_level,
        input color_phase, output ready
    );
endinterface

[sv/rgb_breathing_color_sequencer_top.sv]
// Top level of the RGB breathing color sequencer.
//
// tick_ch carries one tick item per handshake: tick = 1 advances the breathing
// ramp one step, tick = 0 only reports. color_ch returns one color item per
// tick item: red, green and blue levels and the active color phase, all taken
// after the update. cfg_wr_en / cfg_wr_data write peak_level.
//
// The state registers and the output buffer load on the edge that accepts the
// item, and the result is registered. One item is accepted every cycle while
// tick_ch.ready is high; the ramp update is a single add, compare and select
// on the held state.
//
// A two-entry output buffer (result register plus skid register) decouples the
// sides: while the receiver stalls, one more item is accepted into the skid
// register, and tick_ch.ready drops only when both entries are full.
//
// Reset clears all levels, the phase (red) and the direction (rising), sets
// peak_level to 255 and empties the output buffer.
module rgb_breathing_color_sequencer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [rbcs_pkg::LEVEL_W-1:0] cfg_wr_data,
    rbcs_tick_if.sink                    tick_ch,
    rbcs_color_if.source                 color_ch
);
    import rbcs_pkg::*;

    logic [LEVEL_W-1:0] peak_reg;
    phase_t             phase_reg, phase_next;
    logic [LEVEL_W-1:0] red_reg, red_next;
    logic [LEVEL_W-1:0] green_reg, green_next;
    logic [LEVEL_W-1:0] blue_reg, blue_next;
    logic               falling_reg, falling_next;

    color_item_t        head_reg, skid_reg, result_item;
    logic               head_valid_reg, skid_valid_reg;

    logic               in_fire, out_fire, step_en, active;
    logic [LEVEL_W-1:0] sel_level, stepped;
    logic [LEVEL_W:0]   rise_sum;
    logic               fall_after, advance;

    assign in_fire  = tick_ch.valid && tick_ch.ready;
    assign out_fire = head_valid_reg && color_ch.ready;
    assign step_en  = in_fire && tick_ch.tick;

    always_comb
    begin
        active    = 1'b1;
        sel_level = red_reg;
        unique case (phase_reg)
            PH_RED, PH_MAGENTA, PH_YELLOW: sel_level = red_reg;
            PH_GREEN, PH_CYAN, PH_WHITE:   sel_level = green_reg;
            PH_BLUE:                       sel_level = blue_reg;
            default:                       active    = 1'b0;
        endcase
    end

    always_comb
    begin
        rise_sum = {1'b0, sel_level} + {{LEVEL_W{1'b0}}, 1'b1};
        if (!falling_reg)
        begin
            if (rise_sum < {1'b0, peak_reg})
                stepped = sel_level + RISE_STEP;
            else
                stepped = sel_level + 8'd1;
            fall_after = (stepped >= peak_reg);
        end
        else
        begin
            if (sel_level > 8'd1)
                stepped = sel_level - FALL_STEP;
            else
                stepped = sel_level - 8'd1;
            fall_after = (stepped != '0);
        end
        advance = (stepped == '0) && !fall_after;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        falling_next = falling_reg;
        if (step_en && active)
        begin
            falling_next = fall_after;
            if (advance)
                phase_next = (phase_reg == PH_WHITE) ? PH_RED
                                                     : phase_t'(phase_reg + 3'd1);
            unique case (phase_reg)
                PH_RED:     red_next = stepped;
                PH_GREEN:   green_next = stepped;
                PH_BLUE:    blue_next = stepped;
                PH_MAGENTA:
                begin
                    red_next  = stepped;
                    blue_next = stepped;
                end
                PH_YELLOW:
                begin
                    red_next   = stepped;
                    green_next = stepped;
                end
                PH_CYAN:
                begin
                    green_next = stepped;
                    blue_next  = stepped;
                end
                PH_WHITE:
                begin
                    red_next   = stepped;
                    green_next = stepped;
                    blue_next  = stepped;
                end
                default:    red_next = red_reg;
            endcase
        end
    end

    always_comb
    begin
        result_item.red_level   = red_next;
        result_item.green_level = green_next;
        result_item.blue_level  = blue_next;
        result_item.color_phase = phase_next;
    end

    // Hold peak and ramp state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg    <= PEAK_RESET;
            phase_reg   <= PH_RED;
            red_reg     <= '0;
            green_reg   <= '0;
            blue_reg    <= '0;
            falling_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                peak_reg <= cfg_wr_data;
            phase_reg   <= phase_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            falling_reg <= falling_next;
        end
    end

    // Output buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!head_valid_reg || out_fire)
        begin
            head_valid_reg <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload.
    always_ff @(posedge clk)
    begin
        if (!head_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
                head_reg <= skid_reg;
            else
                head_reg <= result_item;
        end
        else if (in_fire)
        begin
            skid_reg <= result_item;
        end
    end

    assign tick_ch.ready        = !skid_valid_reg;
    assign color_ch.valid       = head_valid_reg;
    assign color_ch.red_level   = head_reg.red_level;
    assign color_ch.green_level = head_reg.green_level;
    assign color_ch.blue_level  = head_reg.blue_level;
    assign color_ch.color_phase = head_reg.color_phase;

endmodule

[sv/rbcs_checker.sv]
// Port-level checker for the RGB breathing color sequencer, bound to the top level.
module rbcs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_level,
    input logic [7:0] green_level,
    input logic [7:0] blue_level,
    input logic [2:0] color_phase
);
    import rbcs_pkg::*;

    // Stalled item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({red_level, green_level, blue_level, color_phase}))
        else $error("stalled color item changed");

    // Input backpressure only with a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("tick channel stalled with empty output");

    // Mixed phases track their follower channels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (color_phase == PH_MAGENTA) |-> red_level == blue_level)
        else $error("magenta phase with red and blue apart");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (color_phase == PH_YELLOW) |-> red_level == green_level)
        else $error("yellow phase with red and green apart");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (color_phase == PH_WHITE)
            |-> red_level == green_level && green_level == blue_level)
        else $error("white phase with unequal levels");

endmodule

bind rgb_breathing_color_sequencer_top rbcs_checker u_rbcs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (tick_ch.ready),
    .out_valid   (color_ch.valid),
    .out_ready   (color_ch.ready),
    .red_level   (color_ch.red_level),
    .green_level (color_ch.green_level),
    .blue_level  (color_ch.blue_level),
    .color_phase (color_ch.color_phase)
);

[sim/tb_rgb_breathing_color_sequencer_top.sv]
// Testbench for the RGB breathing color sequencer: random ticks and peaks, checked item by item.
`timescale 1ns / 100ps

module tb_rgb_breathing_color_sequencer_top;
    import rbcs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    class color_scoreboard;
        logic [LEVEL_W-1:0] peak;
        phase_t             phase;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        bit                 falling;
        color_item_t        color_q[$];
        int                 errors;

        function new();
            peak    = PEAK_RESET;
            phase   = PH_RED;
            red     = '0;
            green   = '0;
            blue    = '0;
            falling = 1'b0;
            errors  = 0;
        endfunction

        function void set_peak(logic [LEVEL_W-1:0] value);
            peak = value;
        endfunction

        function int pending();
            return color_q.size();
        endfunction

        function logic [LEVEL_W-1:0] ramp(logic [LEVEL_W-1:0] level);
            int top;
            top = int'(peak);
            if (!falling) begin
                if (int'(level) < top - 1)
                    level = level + RISE_STEP;
                else
                    level = level + 8'd1;
                if (int'(level) >= top)
                    falling = 1'b1;
            end
            else begin
                if (level > 8'd1)
                    level = level - FALL_STEP;
                else
                    level = level - 8'd1;
                if (level == 8'd0)
                    falling = 1'b0;
            end
            return level;
        endfunction

        function void note_tick(bit t);
            color_item_t        want;
            logic [LEVEL_W-1:0] lead;
            bit                 stepped;
            stepped = 1'b1;
            lead    = '0;
            if (t) begin
                case (phase)
                    PH_RED:
                    begin
                        red  = ramp(red);
                        lead = red;
                    end
                    PH_GREEN:
                    begin
                        green = ramp(green);
                        lead  = green;
                    end
                    PH_BLUE:
                    begin
                        blue = ramp(blue);
                        lead = blue;
                    end
                    PH_MAGENTA:
                    begin
                        red  = ramp(red);
                        blue = red;
                        lead = red;
                    end
                    PH_YELLOW:
                    begin
                        red   = ramp(red);
                        green = red;
                        lead  = red;
                    end
                    PH_CYAN:
                    begin
                        green = ramp(green);
                        blue  = green;
                        lead  = green;
                    end
                    PH_WHITE:
                    begin
                        green = ramp(green);
                        blue  = green;
                        red   = green;
                        lead  = green;
                    end
                    default:
                        stepped = 1'b0;
                endcase
                if (stepped && lead == 8'd0 && !falling)
                    phase = (phase == PH_WHITE) ? PH_RED : phase_t'(phase + 3'd1);
            end
            want.red_level   = red;
            want.green_level = green;
            want.blue_level  = blue;
            want.color_phase = phase;
            color_q.push_back(want);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_color(color_item_t got);
            color_item_t want;
            if (color_q.size() == 0) begin
                report_mismatch("unexpected color item, red", int'(got.red_level), -1);
            end
            else begin
                want = color_q.pop_front();
                if (got.red_level !== want.red_level)
                    report_mismatch("red_level", int'(got.red_level),
                                    int'(want.red_level));
                if (got.green_level !== want.green_level)
                    report_mismatch("green_level", int'(got.green_level),
                                    int'(want.green_level));
                if (got.blue_level !== want.blue_level)
                    report_mismatch("blue_level", int'(got.blue_level),
                                    int'(want.blue_level));
                if (got.color_phase !== want.color_phase)
                    report_mismatch("color_phase", int'(got.color_phase),
                                    int'(want.color_phase));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [LEVEL_W-1:0] cfg_wr_data;
    int                 cycle_count;
    int                 tx_idle_pct;
    int                 rx_stall_pct;
    color_scoreboard    sb;

    rbcs_tick_if  tick_ch();
    rbcs_color_if color_ch();

    rgb_breathing_color_sequencer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick_ch     (tick_ch),
        .color_ch    (color_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        color_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        color_item_t got;
        if (rst_n && color_ch.valid && color_ch.ready) begin
            got.red_level   = color_ch.red_level;
            got.green_level = color_ch.green_level;
            got.blue_level  = color_ch.blue_level;
            got.color_phase = color_ch.color_phase;
            sb.check_color(got);
        end
    end

    task send_tick(input bit t);
        @(negedge clk);
        tick_ch.valid <= 1'b1;
        tick_ch.tick  <= t;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        sb.note_tick(t);
    endtask

    task hold_until_drained();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task write_peak(input logic [LEVEL_W-1:0] value);
        hold_until_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        sb.set_peak(value);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task send_random_ticks(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 199) == 0)
                hold_until_drained();
            while ($urandom_range(0, 99) < tx_idle_pct) begin
                @(negedge clk);
                tick_ch.valid <= 1'b0;
                tick_ch.tick  <= 1'($urandom_range(0, 1));
            end
            send_tick($urandom_range(0, 9) != 0);
        end
    endtask

    initial begin
        int                 tx_by_mode[4];
        int                 rx_by_mode[4];
        int                 seg;
        int                 n;
        int                 count;
        logic [LEVEL_W-1:0] peak;

        tx_by_mode     = '{0, 76, 0, 34};
        rx_by_mode     = '{0, 0, 76, 34};
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        cycle_count    = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        tick_ch.valid  = 1'b0;
        tick_ch.tick   = 1'b0;
        color_ch.ready = 1'b1;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        write_peak(8'd1);
        for (n = 0; n < 20; n++)
            send_tick(n != 9);

        for (seg = 0; seg < 12; seg++) begin
            if (seg == 0) begin
                peak  = 8'd255;
                count = 500;
            end
            else if (seg == 1) begin
                peak  = 8'd1;
                count = 100;
            end
            else begin
                if ($urandom_range(0, 3) == 0)
                    peak = LEVEL_W'($urandom_range(1, 255));
                else
                    peak = LEVEL_W'($urandom_range(2, 24));
                count = 125;
            end
            write_peak(peak);
            tx_idle_pct  = tx_by_mode[seg % 4];
            rx_stall_pct = rx_by_mode[seg % 4];
            send_random_ticks(count);
        end

        hold_until_drained();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
